// File: hw/rtl/sparse_polynomial_add_merge_defines.svh
// Assertion macros shared by the checker of the sparse polynomial adder.
// No dependencies; include by bare file name.
`ifndef SPARSE_POLYNOMIAL_ADD_MERGE_DEFINES_SVH
`define SPARSE_POLYNOMIAL_ADD_MERGE_DEFINES_SVH

// same-cycle implication, disabled while reset is high
`define SPAM_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled while reset is high
`define SPAM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hw/rtl/spam_pkg.sv
// Package for the sparse polynomial adder: codes, term and result types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package spam_pkg;

   localparam int MAX_TERMS_DEF = 32;

   typedef enum logic [1:0] {
      REQ_LOAD_A = 2'd0,
      REQ_LOAD_B = 2'd1,
      REQ_START  = 2'd2
   } req_code_type;

   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } state_type;

   // one stored term: power in the upper half, raw coefficient below
   typedef struct packed {
      logic        [15:0] power;
      logic signed [15:0] coeff;
   } term_type;

   typedef struct packed {
      logic signed [16:0] sum_coeff;
      logic        [15:0] term_power;
      logic               term_valid;
      logic               last;
      logic               overflow;
   } rsp_data_type;

endpackage

`default_nettype wire

// File: hw/rtl/sparse_polynomial_add_merge.sv
// Top level of the sparse polynomial adder: two term memories and the merge control.
// Depends on spam_pkg, spam_term_mem and spam_merge_ctrl.
//
//   channel   handshake             beat
//   req_      start & !busy         req_type, req_coeff, req_power
//   rsp_      rsp_strobe            sum_coeff, term_power, term_valid, last, overflow
//
// A load beat does not raise busy; the next beat may follow at once.
// A start beat yields one result term per cycle (A + B minus matched powers), set by the
// single registered read per list memory each cycle; busy is high for that pass.
// With both lists empty a start yields one invalid result and busy never rises.
// Each result appears the cycle after it is formed. The receiver cannot stall.
// Reset is synchronous: counts, overflow flag and state clear; memories need no sweep.
`timescale 1ns / 1ps
`default_nettype none

module sparse_polynomial_add_merge
   import spam_pkg::*;
#(
   parameter int MAX_TERMS = MAX_TERMS_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic [1:0]         req_type,
   input  wire logic signed [15:0] req_coeff,
   input  wire logic [15:0]        req_power,
   output logic                    rsp_strobe,
   output logic signed [16:0]      rsp_sum_coeff,
   output logic [15:0]             rsp_term_power,
   output logic                    rsp_term_valid,
   output logic                    rsp_last,
   output logic                    rsp_overflow
);

   localparam int AW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
   localparam int CW = $clog2(MAX_TERMS + 1);

   logic         wr_a, wr_b;
   logic [AW-1:0] wr_addr, rd_addr_a, rd_addr_b;
   term_type     wr_data, head_a, head_b;
   rsp_data_type rsp_data;

   // list A store
   spam_term_mem #(
      .DEPTH (MAX_TERMS),
      .AW    (AW)
   ) u_mem_a (
      .clock   (clock),
      .wr_en   (wr_a),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr_a),
      .rd_data (head_a)
   );

   // list B store
   spam_term_mem #(
      .DEPTH (MAX_TERMS),
      .AW    (AW)
   ) u_mem_b (
      .clock   (clock),
      .wr_en   (wr_b),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr_b),
      .rd_data (head_b)
   );

   // heads are read at the next index each cycle, so the merge never waits on memory
   spam_merge_ctrl #(
      .MAX_TERMS (MAX_TERMS),
      .AW        (AW),
      .CW        (CW)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_type   (req_type),
      .req_coeff  (req_coeff),
      .req_power  (req_power),
      .head_a     (head_a),
      .head_b     (head_b),
      .busy       (busy),
      .wr_a       (wr_a),
      .wr_b       (wr_b),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .rd_addr_a  (rd_addr_a),
      .rd_addr_b  (rd_addr_b),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   assign rsp_sum_coeff  = rsp_data.sum_coeff;
   assign rsp_term_power = rsp_data.term_power;
   assign rsp_term_valid = rsp_data.term_valid;
   assign rsp_last       = rsp_data.last;
   assign rsp_overflow   = rsp_data.overflow;

endmodule

`default_nettype wire

// File: hw/rtl/spam_term_mem.sv
// Term store for one list: single write port, one registered read port.
// Depends on spam_pkg.
`timescale 1ns / 1ps
`default_nettype none

module spam_term_mem
   import spam_pkg::*;
#(
   parameter int DEPTH = MAX_TERMS_DEF,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire term_type      wr_data,
   input  wire logic [AW-1:0] rd_addr,
   output term_type           rd_data
);

   term_type term_mem [DEPTH];
   term_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         term_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= term_mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: hw/rtl/spam_merge_ctrl.sv
// Load and merge control: list counts, head indexes, compare/add, result register.
// Depends on spam_pkg; drives the two spam_term_mem instances.
`timescale 1ns / 1ps
`default_nettype none

module spam_merge_ctrl
   import spam_pkg::*;
#(
   parameter int MAX_TERMS = MAX_TERMS_DEF,
   parameter int AW        = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1,
   parameter int CW        = $clog2(MAX_TERMS + 1)
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire logic [1:0]    req_type,
   input  wire logic [15:0]   req_coeff,
   input  wire logic [15:0]   req_power,
   input  wire term_type      head_a,
   input  wire term_type      head_b,
   output logic               busy,
   output logic               wr_a,
   output logic               wr_b,
   output logic [AW-1:0]      wr_addr,
   output term_type           wr_data,
   output logic [AW-1:0]      rd_addr_a,
   output logic [AW-1:0]      rd_addr_b,
   output logic               rsp_strobe,
   output rsp_data_type       rsp_data
);

   localparam logic [CW-1:0] FULL = CW'(MAX_TERMS);

   state_type     state_ff, state_in;
   logic [CW-1:0] count_a_ff, count_a_in;
   logic [CW-1:0] count_b_ff, count_b_in;
   logic [CW-1:0] ia_ff, ia_in;
   logic [CW-1:0] ib_ff, ib_in;
   logic          ovf_ff, ovf_in;
   logic          strobe_ff, strobe_in;
   rsp_data_type  data_ff, data_in;

   logic               accept;
   logic               is_load_a, is_load_b, is_start;
   logic               lists_empty;
   logic               a_ok, b_ok, take_a, take_b, done;
   logic signed [16:0] ca_ext, cb_ext;
   logic [CW-1:0]      ia_nx, ib_nx;

   // decode and merge datapath
   always_comb begin
      accept    = start && (state_ff == ST_IDLE);
      is_load_a = 1'b0;
      is_load_b = 1'b0;
      is_start  = 1'b0;
      case (req_type)
         REQ_LOAD_A: is_load_a = accept;
         REQ_LOAD_B: is_load_b = accept;
         REQ_START:  is_start  = accept;
         default:    ;
      endcase
      lists_empty = (count_a_ff == '0) && (count_b_ff == '0);

      a_ok   = ia_ff < count_a_ff;
      b_ok   = ib_ff < count_b_ff;
      take_a = a_ok && (!b_ok || (head_a.power >= head_b.power));
      take_b = b_ok && (!a_ok || (head_b.power >= head_a.power));
      ca_ext = take_a ? 17'(head_a.coeff) : '0;
      cb_ext = take_b ? 17'(head_b.coeff) : '0;
      ia_nx  = ia_ff + CW'(take_a);
      ib_nx  = ib_ff + CW'(take_b);
      done   = (ia_nx >= count_a_ff) && (ib_nx >= count_b_ff);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (is_start && !lists_empty) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (done) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs and datapath next values
   always_comb begin
      busy       = (state_ff == ST_RUN);
      wr_a       = is_load_a && (count_a_ff < FULL);
      wr_b       = is_load_b && (count_b_ff < FULL);
      wr_addr    = is_load_b ? count_b_ff[AW-1:0] : count_a_ff[AW-1:0];
      wr_data    = '{power: req_power, coeff: req_coeff};
      count_a_in = count_a_ff + CW'(wr_a);
      count_b_in = count_b_ff + CW'(wr_b);
      ovf_in     = ovf_ff || (is_load_a && !wr_a) || (is_load_b && !wr_b);
      ia_in      = '0;
      ib_in      = '0;
      rd_addr_a  = '0;
      rd_addr_b  = '0;
      strobe_in  = 1'b0;
      data_in    = '{sum_coeff: '0, term_power: '0, term_valid: 1'b0,
                     last: 1'b1, overflow: ovf_ff};
      case (state_ff)
         ST_IDLE: begin
            // both lists empty: a single invalid result, no merge pass
            if (is_start && lists_empty) begin
               strobe_in = 1'b1;
               ovf_in    = 1'b0;
            end
         end
         ST_RUN: begin
            ia_in     = ia_nx;
            ib_in     = ib_nx;
            rd_addr_a = ia_nx[AW-1:0];
            rd_addr_b = ib_nx[AW-1:0];
            strobe_in = 1'b1;
            data_in   = '{sum_coeff: ca_ext + cb_ext,
                          term_power: take_a ? head_a.power : head_b.power,
                          term_valid: 1'b1, last: done, overflow: ovf_ff};
            if (done) begin
               count_a_in = '0;
               count_b_in = '0;
               ovf_in     = 1'b0;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         count_a_ff <= '0;
         count_b_ff <= '0;
         ia_ff      <= '0;
         ib_ff      <= '0;
         ovf_ff     <= 1'b0;
         strobe_ff  <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_a_ff <= count_a_in;
         count_b_ff <= count_b_in;
         ia_ff      <= ia_in;
         ib_ff      <= ib_in;
         ovf_ff     <= ovf_in;
         strobe_ff  <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_data   = data_ff;

endmodule

`default_nettype wire

// File: hw/rtl/spam_checker.sv
// Port-level checker for the sparse polynomial adder, bound to the top level.
// Depends on spam_pkg and sparse_polynomial_add_merge_defines.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "sparse_polynomial_add_merge_defines.svh"

module spam_checker
   import spam_pkg::*;
(
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       start,
   input wire logic       busy,
   input wire logic [1:0] req_type,
   input wire logic       rsp_strobe,
   input wire logic       rsp_term_valid,
   input wire logic       rsp_last
);

   // the merge pass ends with the final beat
   `SPAM_ASSERT_NOW(a_busy_ends_on_last, clock, reset, !$past(reset) && $fell(busy), rsp_strobe && rsp_last, "busy fell without a final result")

   // a non-final beat only while the merge runs
   `SPAM_ASSERT_NOW(a_mid_beat_busy, clock, reset, rsp_strobe && !rsp_last, busy, "non-final result outside a merge")

   // a beat with no merge behind it is the empty-lists marker
   `SPAM_ASSERT_NOW(a_idle_beat_empty, clock, reset, !$past(reset) && rsp_strobe && !$past(busy), !rsp_term_valid && rsp_last, "unexpected result from idle")

   // a start always leads to a merge or the empty marker
   `SPAM_ASSERT_NEXT(a_start_answers, clock, reset, start && !busy && (req_type == REQ_START), busy || rsp_strobe, "start produced nothing")

endmodule

bind sparse_polynomial_add_merge spam_checker u_spam_checker (.*);

`default_nettype wire
